/* design/sis_pkg.sv */
// Package for the string instruction step block: operation and prefix codes,
// flag bit positions, port word structs and pipeline stage structs.
// Depends on nothing; imported by sis_flags and string_instruction_step_top.
package sis_pkg;

  // Operation codes; code 7 is unused and executes nothing
  localparam logic [2:0] OP_INS    = 3'd0;
  localparam logic [2:0] OP_OUTS   = 3'd1;
  localparam logic [2:0] OP_MOVS   = 3'd2;
  localparam logic [2:0] OP_CMPS   = 3'd3;
  localparam logic [2:0] OP_STOS   = 3'd4;
  localparam logic [2:0] OP_LODS   = 3'd5;
  localparam logic [2:0] OP_SCAS   = 3'd6;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // Repeat prefix codes; code 3 acts as no prefix
  localparam logic [1:0] REP_NONE     = 2'd0;
  localparam logic [1:0] REP_WHILE_Z  = 2'd1;
  localparam logic [1:0] REP_WHILE_NZ = 2'd2;
  localparam logic [1:0] REP_UNUSED   = 2'd3;

  // Flag bit positions
  localparam int FLAG_CF = 0;
  localparam int FLAG_PF = 1;
  localparam int FLAG_AF = 2;
  localparam int FLAG_ZF = 3;
  localparam int FLAG_SF = 4;
  localparam int FLAG_OF = 5;

  localparam int DATA_W = 16;
  localparam int FLAG_W = 6;

  typedef struct packed {
    logic [2:0]        op;
    logic              word_size;
    logic [1:0]        rep_mode;
    logic              dir_down;
    logic [DATA_W-1:0] count_in;
    logic [DATA_W-1:0] src_index;
    logic [DATA_W-1:0] dst_index;
    logic [DATA_W-1:0] src_data;
    logic [DATA_W-1:0] dst_data;
    logic [DATA_W-1:0] acc_in;
  } in_word_t;

  typedef struct packed {
    logic              executed;
    logic [DATA_W-1:0] count_out;
    logic [DATA_W-1:0] src_index_out;
    logic [DATA_W-1:0] dst_index_out;
    logic              mem_write;
    logic              port_write;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] acc_out;
    logic              flags_valid;
    logic [FLAG_W-1:0] flags;
    logic              repeat_again;
  } out_word_t;

  // Decoded item after the first stage
  typedef struct packed {
    logic              executed;
    logic              prefixed;
    logic [1:0]        rep_mode;
    logic              word_size;
    logic              use_si;
    logic              use_di;
    logic              mem_write;
    logic              port_write;
    logic              flags_valid;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] cmp_x;
    logic [DATA_W-1:0] cmp_y;
    logic [DATA_W-1:0] delta;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] src_index;
    logic [DATA_W-1:0] dst_index;
  } dec_t;

  // Item after the arithmetic stage
  typedef struct packed {
    logic              executed;
    logic              prefixed;
    logic [1:0]        rep_mode;
    logic              word_size;
    logic              mem_write;
    logic              port_write;
    logic              flags_valid;
    logic              borrow;
    logic              count_nz;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] cmp_x;
    logic [DATA_W-1:0] cmp_y;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] src_index;
    logic [DATA_W-1:0] dst_index;
  } arith_t;

endpackage

/* design/sis_flags.sv */
// Subtract flags for byte/word compares: carry, parity, aux, zero, sign, overflow.
// Depends on sis_pkg for widths and flag bit positions.
module sis_flags (
  input  logic                       word_size,
  input  logic                       borrow,
  input  logic [sis_pkg::DATA_W-1:0] x,
  input  logic [sis_pkg::DATA_W-1:0] y,
  input  logic [sis_pkg::DATA_W-1:0] diff,
  output logic [sis_pkg::FLAG_W-1:0] flags,
  output logic                       zero
);
  import sis_pkg::*;

  logic top_x;
  logic top_y;
  logic top_r;

  // Pick the sign bits at the operation size
  assign top_x = word_size ? x[15] : x[7];
  assign top_y = word_size ? y[15] : y[7];
  assign top_r = word_size ? diff[15] : diff[7];
  assign zero  = (diff == '0);

  // Assemble the flag word
  always_comb begin
    flags          = '0;
    flags[FLAG_CF] = borrow;
    flags[FLAG_PF] = ~^diff[7:0];
    flags[FLAG_AF] = x[4] ^ y[4] ^ diff[4];
    flags[FLAG_ZF] = zero;
    flags[FLAG_SF] = top_r;
    flags[FLAG_OF] = (top_x ^ top_y) & (top_x ^ top_r);
  end

endmodule

/* design/string_instruction_step_top.sv */
// String instruction step: executes one iteration of ins/outs/movs/cmps/stos/lods/scas.
// Three-stage pipeline; depends on sis_pkg and sis_flags.
//
// Usage:
//   Input channel: drive in_word with the operation, registers and fetched
//   data and raise start. A word is taken at each rising edge with start high
//   and busy low. busy is high during reset and drops at the next rising edge
//   once reset is released; after that a new word can enter every cycle: throughput is
//   one word per clock.
//   Result channel: out_valid strobes for one cycle with out_word holding the
//   result. The accepted word passes three registered stages: stage 1 decodes the
//   operation and masks operands, stage 2 does the 16-bit index adds, count
//   decrement and compare subtract, stage 3 forms the flags and the repeat
//   decision into the output register.
//   Results leave in the order words came in. The receiver cannot hold
//   results off, so the pipeline never stalls.
//   Reset (rst_n low, synchronous) clears all stage valid bits; words in
//   flight are dropped and no strobe follows them.
module string_instruction_step_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sis_pkg::in_word_t  in_word,
  output logic               out_valid,
  output sis_pkg::out_word_t out_word
);
  import sis_pkg::*;

  logic      busy_r;
  logic      accept;
  dec_t      dec_nxt;
  dec_t      dec_r;
  logic      dec_vld_r;
  arith_t    ar_nxt;
  arith_t    ar_r;
  logic      ar_vld_r;
  out_word_t out_nxt;
  out_word_t out_r;
  logic      out_vld_r;
  logic [16:0] diff_wide;
  logic [FLAG_W-1:0] cmp_flags;
  logic      cmp_zero;
  logic      stop_on_zf;

  // Hold busy through reset; it clears at the next edge once reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // Stage 1: decode operation, mask operands, pick step
  always_comb begin
    logic [DATA_W-1:0] mask;
    logic              prefixed;
    mask     = in_word.word_size ? 16'hFFFF : 16'h00FF;
    prefixed = (in_word.rep_mode == REP_WHILE_Z) || (in_word.rep_mode == REP_WHILE_NZ);
    dec_nxt             = '0;
    dec_nxt.prefixed    = prefixed;
    dec_nxt.rep_mode    = in_word.rep_mode;
    dec_nxt.word_size   = in_word.word_size;
    dec_nxt.acc         = in_word.acc_in;
    dec_nxt.count       = in_word.count_in;
    dec_nxt.src_index   = in_word.src_index;
    dec_nxt.dst_index   = in_word.dst_index;
    dec_nxt.delta       = in_word.dir_down ?
                          (in_word.word_size ? 16'hFFFE : 16'hFFFF) :
                          (in_word.word_size ? 16'h0002 : 16'h0001);
    dec_nxt.executed    = (in_word.op != OP_UNUSED) && (!prefixed || (in_word.count_in != '0));
    if (dec_nxt.executed) begin
      unique case (in_word.op)
        OP_INS: begin
          dec_nxt.mem_write  = 1'b1;
          dec_nxt.write_data = in_word.src_data & mask;
          dec_nxt.use_di     = 1'b1;
        end
        OP_OUTS: begin
          dec_nxt.port_write = 1'b1;
          dec_nxt.write_data = in_word.src_data & mask;
          dec_nxt.use_si     = 1'b1;
        end
        OP_MOVS: begin
          dec_nxt.mem_write  = 1'b1;
          dec_nxt.write_data = in_word.src_data & mask;
          dec_nxt.use_si     = 1'b1;
          dec_nxt.use_di     = 1'b1;
        end
        OP_CMPS: begin
          dec_nxt.flags_valid = 1'b1;
          dec_nxt.cmp_x       = in_word.src_data & mask;
          dec_nxt.cmp_y       = in_word.dst_data & mask;
          dec_nxt.use_si      = 1'b1;
          dec_nxt.use_di      = 1'b1;
        end
        OP_STOS: begin
          dec_nxt.mem_write  = 1'b1;
          dec_nxt.write_data = in_word.acc_in & mask;
          dec_nxt.use_di     = 1'b1;
        end
        OP_LODS: begin
          dec_nxt.acc    = in_word.word_size ? in_word.src_data :
                           {in_word.acc_in[15:8], in_word.src_data[7:0]};
          dec_nxt.use_si = 1'b1;
        end
        OP_SCAS: begin
          dec_nxt.flags_valid = 1'b1;
          dec_nxt.cmp_x       = in_word.acc_in & mask;
          dec_nxt.cmp_y       = in_word.dst_data & mask;
          dec_nxt.use_di      = 1'b1;
        end
        default: begin
          dec_nxt.executed = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
    end else begin
      dec_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
  end

  // Stage 2: step indices, decrement count, subtract operands
  assign diff_wide = {1'b0, dec_r.cmp_x} - {1'b0, dec_r.cmp_y};

  always_comb begin
    ar_nxt             = '0;
    ar_nxt.executed    = dec_r.executed;
    ar_nxt.prefixed    = dec_r.prefixed;
    ar_nxt.rep_mode    = dec_r.rep_mode;
    ar_nxt.word_size   = dec_r.word_size;
    ar_nxt.mem_write   = dec_r.mem_write;
    ar_nxt.port_write  = dec_r.port_write;
    ar_nxt.flags_valid = dec_r.flags_valid;
    ar_nxt.write_data  = dec_r.write_data;
    ar_nxt.acc         = dec_r.acc;
    ar_nxt.cmp_x       = dec_r.cmp_x;
    ar_nxt.cmp_y       = dec_r.cmp_y;
    ar_nxt.borrow      = diff_wide[16];
    ar_nxt.diff        = dec_r.word_size ? diff_wide[15:0] : {8'h00, diff_wide[7:0]};
    ar_nxt.src_index   = dec_r.use_si ? (dec_r.src_index + dec_r.delta) : dec_r.src_index;
    ar_nxt.dst_index   = dec_r.use_di ? (dec_r.dst_index + dec_r.delta) : dec_r.dst_index;
    ar_nxt.count       = (dec_r.executed && dec_r.prefixed) ? (dec_r.count - 16'd1) :
                         dec_r.count;
    ar_nxt.count_nz    = (ar_nxt.count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ar_vld_r <= 1'b0;
    end else begin
      ar_vld_r <= dec_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ar_r <= ar_nxt;
  end

  // Stage 3: flags and repeat decision
  sis_flags u_flags (
    .word_size (ar_r.word_size),
    .borrow    (ar_r.borrow),
    .x         (ar_r.cmp_x),
    .y         (ar_r.cmp_y),
    .diff      (ar_r.diff),
    .flags     (cmp_flags),
    .zero      (cmp_zero)
  );

  // Compare ends the repeat on the wrong sense of zero
  assign stop_on_zf = ar_r.flags_valid &&
                      (((ar_r.rep_mode == REP_WHILE_Z) && !cmp_zero) ||
                       ((ar_r.rep_mode == REP_WHILE_NZ) && cmp_zero));

  always_comb begin
    out_nxt               = '0;
    out_nxt.executed      = ar_r.executed;
    out_nxt.count_out     = ar_r.count;
    out_nxt.src_index_out = ar_r.src_index;
    out_nxt.dst_index_out = ar_r.dst_index;
    out_nxt.mem_write     = ar_r.mem_write;
    out_nxt.port_write    = ar_r.port_write;
    out_nxt.write_data    = ar_r.write_data;
    out_nxt.acc_out       = ar_r.acc;
    out_nxt.flags_valid   = ar_r.flags_valid;
    out_nxt.flags         = ar_r.flags_valid ? cmp_flags : '0;
    out_nxt.repeat_again  = ar_r.executed && ar_r.prefixed && ar_r.count_nz && !stop_on_zf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= ar_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

`ifndef SYNTH
  // Every accepted word gives a strobe after passing the stage registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted word produced no result");

  // A skipped iteration writes nothing, sets no flags and does not repeat
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.executed) |->
      (!out_word.mem_write && !out_word.port_write &&
       !out_word.flags_valid && !out_word.repeat_again))
    else $error("skipped iteration has side effects");

  // Repeat only with a count left
  a_repeat_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.repeat_again) |-> (out_word.count_out != '0))
    else $error("repeat requested with zero count");

  // Memory and port writes never coincide
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.mem_write && out_word.port_write))
    else $error("write to memory and port at once");

  // Flags stay clear outside compares
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.flags_valid) |-> (out_word.flags == '0))
    else $error("flags set without a compare");
`endif

endmodule

/* verif/tb_string_instruction_step_top.sv */
// Testbench for string_instruction_step_top: directed table, then random words and
// chained repeat runs, all checked field by field against typed expectations or a local predictor.
// Depends on sis_pkg and the design files only.
`timescale 1ns / 100ps

module tb_string_instruction_step_top;
  import sis_pkg::*;

  localparam int N_RANDOM = 1230;
  localparam int N_QUIET  = 200;
  localparam int LATENCY  = 3;

  typedef struct packed {
    logic      typed;
    in_word_t  stim;
    out_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  out_word_t pending_results[$];
  dir_row_t  dir_rows[$];
  int        mismatches = 0;
  int        words_sent = 0;
  bit        idle_on = 1'b1;

  string_instruction_step_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Flags of x minus y at byte or word size; operands arrive masked
  function automatic logic [FLAG_W-1:0] sub_flag_bits(logic [15:0] x, logic [15:0] y,
                                                       logic wide);
    logic [15:0]       d;
    logic [15:0]       r;
    logic [FLAG_W-1:0] f;
    d = x - y;
    r = wide ? d : {8'h00, d[7:0]};
    f = '0;
    f[FLAG_CF] = x < y;
    f[FLAG_PF] = ~^r[7:0];
    f[FLAG_AF] = x[4] ^ y[4] ^ r[4];
    f[FLAG_ZF] = (r == 16'h0000);
    f[FLAG_SF] = wide ? r[15] : r[7];
    f[FLAG_OF] = wide ? ((x[15] ^ y[15]) & (x[15] ^ r[15]))
                      : ((x[7] ^ y[7]) & (x[7] ^ r[7]));
    return f;
  endfunction

  // One iteration of the string instruction
  function automatic out_word_t string_step(in_word_t w);
    out_word_t   o;
    logic [15:0] mask;
    logic [15:0] delta;
    logic        prefixed;
    logic        use_si;
    logic        use_di;
    mask     = w.word_size ? 16'hFFFF : 16'h00FF;
    delta    = w.dir_down ? (w.word_size ? 16'hFFFE : 16'hFFFF)
                          : (w.word_size ? 16'h0002 : 16'h0001);
    prefixed = (w.rep_mode == REP_WHILE_Z) || (w.rep_mode == REP_WHILE_NZ);
    use_si   = 1'b0;
    use_di   = 1'b0;
    o = '0;
    o.count_out     = w.count_in;
    o.src_index_out = w.src_index;
    o.dst_index_out = w.dst_index;
    o.acc_out       = w.acc_in;
    o.executed      = (w.op != OP_UNUSED) && (!prefixed || w.count_in != 16'h0000);
    if (o.executed) begin
      case (w.op)
        OP_INS: begin
          o.mem_write  = 1'b1;
          o.write_data = w.src_data & mask;
          use_di       = 1'b1;
        end
        OP_OUTS: begin
          o.port_write = 1'b1;
          o.write_data = w.src_data & mask;
          use_si       = 1'b1;
        end
        OP_MOVS: begin
          o.mem_write  = 1'b1;
          o.write_data = w.src_data & mask;
          use_si       = 1'b1;
          use_di       = 1'b1;
        end
        OP_CMPS: begin
          o.flags_valid = 1'b1;
          o.flags = sub_flag_bits(w.src_data & mask, w.dst_data & mask, w.word_size);
          use_si  = 1'b1;
          use_di  = 1'b1;
        end
        OP_STOS: begin
          o.mem_write  = 1'b1;
          o.write_data = w.acc_in & mask;
          use_di       = 1'b1;
        end
        OP_LODS: begin
          o.acc_out = w.word_size ? w.src_data : {w.acc_in[15:8], w.src_data[7:0]};
          use_si    = 1'b1;
        end
        OP_SCAS: begin
          o.flags_valid = 1'b1;
          o.flags = sub_flag_bits(w.acc_in & mask, w.dst_data & mask, w.word_size);
          use_di  = 1'b1;
        end
        default: ;
      endcase
      if (use_si) o.src_index_out = w.src_index + delta;
      if (use_di) o.dst_index_out = w.dst_index + delta;
      // Count down under a prefix; compares may end the run early
      if (prefixed) begin
        o.count_out    = w.count_in - 16'h0001;
        o.repeat_again = (o.count_out != 16'h0000);
        if (o.flags_valid) begin
          if (w.rep_mode == REP_WHILE_Z && !o.flags[FLAG_ZF]) o.repeat_again = 1'b0;
          if (w.rep_mode == REP_WHILE_NZ && o.flags[FLAG_ZF]) o.repeat_again = 1'b0;
        end
      end
    end
    return o;
  endfunction

  function automatic in_word_t mk(logic [2:0] op, logic ws, logic [1:0] rep, logic dn,
                                  logic [15:0] cx, logic [15:0] si, logic [15:0] di,
                                  logic [15:0] sd, logic [15:0] dd, logic [15:0] acc);
    in_word_t w;
    w.op        = op;
    w.word_size = ws;
    w.rep_mode  = rep;
    w.dir_down  = dn;
    w.count_in  = cx;
    w.src_index = si;
    w.dst_index = di;
    w.src_data  = sd;
    w.dst_data  = dd;
    w.acc_in    = acc;
    return w;
  endfunction

  function automatic out_word_t exp_word(logic ex, logic [15:0] cx, logic [15:0] si,
                                         logic [15:0] di, logic memw, logic portw,
                                         logic [15:0] wdata, logic [15:0] acc,
                                         logic fv, logic [FLAG_W-1:0] fl, logic again);
    out_word_t o;
    o.executed      = ex;
    o.count_out     = cx;
    o.src_index_out = si;
    o.dst_index_out = di;
    o.mem_write     = memw;
    o.port_write    = portw;
    o.write_data    = wdata;
    o.acc_out       = acc;
    o.flags_valid   = fv;
    o.flags         = fl;
    o.repeat_again  = again;
    return o;
  endfunction

  // Index values that favor the wrap points
  function automatic logic [15:0] near_wrap();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 2));
      1:       return 16'($urandom_range(16'hFFFD, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int       pick;
    pick        = $urandom_range(0, 99);
    w.op        = (pick < 3) ? OP_UNUSED : 3'($urandom_range(0, 6));
    w.word_size = 1'($urandom_range(0, 1));
    pick        = $urandom_range(0, 99);
    w.rep_mode  = (pick < 30) ? REP_NONE : (pick < 60) ? REP_WHILE_Z :
                  (pick < 90) ? REP_WHILE_NZ : REP_UNUSED;
    w.dir_down  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       w.count_in = 16'h0000;
      1:       w.count_in = 16'h0001;
      2, 3, 4: w.count_in = 16'($urandom_range(2, 20));
      default: w.count_in = 16'($urandom);
    endcase
    w.src_index = near_wrap();
    w.dst_index = near_wrap();
    w.src_data  = 16'($urandom);
    w.dst_data  = 16'($urandom);
    w.acc_in    = 16'($urandom);
    // Equal operands now and then so the zero flag gets exercised
    if ($urandom_range(0, 2) == 0) begin
      if (w.op == OP_CMPS) w.dst_data = w.src_data;
      if (w.op == OP_SCAS) w.dst_data = w.acc_in;
    end
    return w;
  endfunction

  // Drive one word, hold it until taken, queue what it should produce
  task automatic issue_word(in_word_t w, logic typed, out_word_t want);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(typed ? want : string_step(w));
    words_sent++;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: %h", out_word);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("executed", 16'(want.executed), 16'(out_word.executed));
        check_field("count_out", want.count_out, out_word.count_out);
        check_field("src_index_out", want.src_index_out, out_word.src_index_out);
        check_field("dst_index_out", want.dst_index_out, out_word.dst_index_out);
        check_field("mem_write", 16'(want.mem_write), 16'(out_word.mem_write));
        check_field("port_write", 16'(want.port_write), 16'(out_word.port_write));
        check_field("write_data", want.write_data, out_word.write_data);
        check_field("acc_out", want.acc_out, out_word.acc_out);
        check_field("flags_valid", 16'(want.flags_valid), 16'(out_word.flags_valid));
        check_field("flags", 16'(want.flags), 16'(out_word.flags));
        check_field("repeat_again", 16'(want.repeat_again), 16'(out_word.repeat_again));
      end
    end
  end

  initial begin
    in_word_t  w;
    out_word_t r;
    dir_row_t  row;
    int        guard;

    // Directed table: typed rows carry their own expectation
    dir_rows.push_back({1'b0, mk(OP_INS, 1'b0, REP_NONE, 1'b0, 16'h0007, 16'h1234,
                        16'h0010, 16'hABCD, 16'h0000, 16'h5555), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_OUTS, 1'b1, REP_NONE, 1'b1, 16'h0003, 16'h0001,
                        16'h8000, 16'hBEEF, 16'h1111, 16'h2222), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_MOVS, 1'b1, REP_WHILE_Z, 1'b0, 16'hFFFF, 16'hFFFF,
                        16'hFFFE, 16'hFFFF, 16'h0000, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_CMPS, 1'b0, REP_WHILE_Z, 1'b0, 16'h0005, 16'h0100,
                        16'h0200, 16'h1142, 16'h2242, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_CMPS, 1'b0, REP_WHILE_Z, 1'b1, 16'h0005, 16'h0100,
                        16'h0200, 16'h0042, 16'h0043, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_CMPS, 1'b1, REP_WHILE_NZ, 1'b0, 16'h0009, 16'h0300,
                        16'h0400, 16'hA5A5, 16'hA5A5, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_CMPS, 1'b1, REP_WHILE_NZ, 1'b1, 16'h0001, 16'h0000,
                        16'h0001, 16'h1234, 16'h4321, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b1, mk(OP_STOS, 1'b0, REP_NONE, 1'b0, 16'h0004, 16'h0020,
                        16'h0030, 16'h0000, 16'h0000, 16'h12EF),
                        exp_word(1'b1, 16'h0004, 16'h0020, 16'h0031, 1'b1, 1'b0, 16'h00EF,
                                 16'h12EF, 1'b0, 6'h00, 1'b0)});
    dir_rows.push_back({1'b0, mk(OP_LODS, 1'b0, REP_WHILE_Z, 1'b0, 16'h0002, 16'h7FFF,
                        16'h0000, 16'h3C5A, 16'h0000, 16'h9900), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_LODS, 1'b1, REP_NONE, 1'b1, 16'h0000, 16'h0000,
                        16'h0000, 16'hFEDC, 16'h0000, 16'h0123), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_SCAS, 1'b0, REP_WHILE_NZ, 1'b0, 16'h0010, 16'h0000,
                        16'h0050, 16'h0000, 16'h0001, 16'hFF00), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_SCAS, 1'b1, REP_WHILE_Z, 1'b0, 16'h0003, 16'h0000,
                        16'h0060, 16'h0000, 16'h0001, 16'h8000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_CMPS, 1'b0, REP_NONE, 1'b0, 16'h0000, 16'h0010,
                        16'h0020, 16'h0080, 16'h0001, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_CMPS, 1'b0, REP_NONE, 1'b0, 16'h0000, 16'h0010,
                        16'h0020, 16'h0010, 16'h0001, 16'h0000), out_word_t'(0)});
    // Repeat with zero count and the unused opcode pass everything through
    dir_rows.push_back({1'b1, mk(OP_MOVS, 1'b1, REP_WHILE_Z, 1'b0, 16'h0000, 16'h4444,
                        16'h5555, 16'h6666, 16'h7777, 16'h8888),
                        exp_word(1'b0, 16'h0000, 16'h4444, 16'h5555, 1'b0, 1'b0, 16'h0000,
                                 16'h8888, 1'b0, 6'h00, 1'b0)});
    dir_rows.push_back({1'b1, mk(OP_CMPS, 1'b0, REP_WHILE_NZ, 1'b1, 16'h0000, 16'hFFFF,
                        16'h0000, 16'h00AA, 16'h00AA, 16'hFFFF),
                        exp_word(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000,
                                 16'hFFFF, 1'b0, 6'h00, 1'b0)});
    dir_rows.push_back({1'b1, mk(OP_UNUSED, 1'b1, REP_NONE, 1'b1, 16'h1357, 16'h2468,
                        16'h369C, 16'hFFFF, 16'hFFFF, 16'hABCD),
                        exp_word(1'b0, 16'h1357, 16'h2468, 16'h369C, 1'b0, 1'b0, 16'h0000,
                                 16'hABCD, 1'b0, 6'h00, 1'b0)});
    // The unused prefix acts as none: runs with a zero count, count kept
    dir_rows.push_back({1'b1, mk(OP_STOS, 1'b1, REP_UNUSED, 1'b0, 16'h0000, 16'h0100,
                        16'h0200, 16'h0000, 16'h0000, 16'hCAFE),
                        exp_word(1'b1, 16'h0000, 16'h0100, 16'h0202, 1'b1, 1'b0, 16'hCAFE,
                                 16'hCAFE, 1'b0, 6'h00, 1'b0)});
    dir_rows.push_back({1'b0, mk(OP_SCAS, 1'b1, REP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_INS, 1'b0, REP_NONE, 1'b0, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_SCAS, 1'b1, REP_NONE, 1'b0, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 16'hFFFF, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_OUTS, 1'b0, REP_WHILE_Z, 1'b0, 16'h0002, 16'hFFFF,
                        16'h0000, 16'h99AA, 16'h0000, 16'h0000), out_word_t'(0)});
    dir_rows.push_back({1'b0, mk(OP_INS, 1'b1, REP_WHILE_NZ, 1'b1, 16'h0001, 16'h0000,
                        16'h0001, 16'h8001, 16'h0000, 16'h0000), out_word_t'(0)});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      issue_word(row.stim, row.typed, row.want);
    end

    // Random part: chained repeat runs mixed with single noisy words
    while (words_sent < dir_rows.size() + N_RANDOM) begin
      idle_on = (words_sent < dir_rows.size() + N_RANDOM - N_QUIET) &&
                (((words_sent / 64) % 3) != 2);
      w = rand_word();
      if ($urandom_range(0, 4) != 0 && w.op != OP_UNUSED &&
          (w.rep_mode == REP_WHILE_Z || w.rep_mode == REP_WHILE_NZ)) begin
        // Keep chains short so a run stays near its word budget
        if ($urandom_range(0, 7) != 0 || w.count_in > 16'd20) begin
          w.count_in = 16'($urandom_range(1, 12));
        end
        forever begin
          issue_word(w, 1'b0, out_word_t'(0));
          r = string_step(w);
          if (!r.repeat_again) break;
          // Feed the stepped registers back with fresh data
          w.count_in  = r.count_out;
          w.src_index = r.src_index_out;
          w.dst_index = r.dst_index_out;
          w.acc_in    = r.acc_out;
          w.src_data  = 16'($urandom);
          w.dst_data  = 16'($urandom);
          if (w.rep_mode == REP_WHILE_Z && $urandom_range(0, 4) != 0) begin
            w.dst_data = (w.op == OP_CMPS) ? w.src_data : w.acc_in;
          end
        end
      end else begin
        issue_word(w, 1'b0, out_word_t'(0));
      end
    end
    start <= 1'b0;

    // Drain the pipeline, then keep clocking to catch stray strobes
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
